/* hdl/bpc_pkg.sv */
// shared types and constants for barometric pressure compensation
`default_nettype none
package bpc_pkg;
  localparam int DataW = 32;
  localparam int CfgIdxW = 3;
  localparam int RawW = 19;

  localparam logic [CfgIdxW-1:0] RegAc1 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAc2 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAc3 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAc4 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAc56 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegB12 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMcMd = 3'd6;
  localparam logic [CfgIdxW-1:0] RegOss = 3'd7;

  // datapath micro-operations, one per controller step, in sequence order
  typedef enum logic [4:0] {
    OP_NONE,
    OP_T_SUB,     // t = raw - ac6
    OP_T_MUL,     // prod = t*ac5
    OP_T_X1,      // x1 = asr(prod,15)
    OP_T_DEN,     // t = x1 + md
    OP_T_DIV,     // start mc<<11 / t
    OP_T_B5,      // t = x1 + quotient
    OP_T_FIN,     // value, stored term
    OP_P_B6,      // b6
    OP_P_SQ,      // prod = b6*b6
    OP_P_SQS,     // sq = asr(prod,12), prod = ac2*b6
    OP_P_X2,      // acc = asr(prod,11), prod = b2*sq
    OP_P_X3,      // acc += asr(prod,11), prod = ac3*b6
    OP_P_B3,      // t = (ac1*4+acc)<<oss, x1 = asr(prod,13), prod = b1*sq
    OP_P_B3F,     // b3, acc = x1 + asr(prod,16)
    OP_P_B4S,     // t = b4 operand, b7 = raw - b3
    OP_P_B4M,     // prod = ac4*t
    OP_P_B4,      // b4, prod = b7*(50000>>oss)
    OP_P_B7,      // b7
    OP_P_DIV,     // start p divide
    OP_P_PQ,      // p from quotient
    OP_P_H,       // h, prod = -7357*p
    OP_P_HH,      // x1 = asr(prod,16), prod = h*h
    OP_P_HM,      // prod = prod*3038
    OP_P_X1,      // acc = asr(prod,16) + x1 + 3791
    OP_P_FIN      // value
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_zero;
  } dp_sts_t;
endpackage
`default_nettype wire

/* hdl/bpc_div.sv */
// iterative 32-bit unsigned or signed divider, one quotient bit per cycle
`default_nettype none
module bpc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        sgn,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             busy,
  output logic             zero,
  output logic [31:0]      quot
);
  logic [31:0] rem, q, d;
  logic [5:0]  cnt;
  logic        neg;
  logic [32:0] trial;

  // shift-subtract step
  assign trial = {rem, q[31]} - {1'b0, d};
  assign quot = neg ? (32'd0 - q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      zero <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      zero <= (den == 32'd0);
      busy <= (den != 32'd0);
      cnt <= 6'd32;
      rem <= '0;
      q <= (sgn && num[31]) ? (32'd0 - num) : num;
      d <= (sgn && den[31]) ? (32'd0 - den) : den;
      neg <= sgn && (num[31] ^ den[31]);
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        q <= {q[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], q[31]};
        q <= {q[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* hdl/bpc_datapath.sv */
// registers, shared multiplier and divider of the compensation datapath
`default_nettype none
module bpc_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [bpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [bpc_pkg::DataW-1:0]    cfg_data,
  input  wire logic [bpc_pkg::RawW-1:0]     raw_in,
  input  wire bpc_pkg::dp_cmd_t             cmd,
  output bpc_pkg::dp_sts_t                  sts,
  output logic [bpc_pkg::DataW-1:0]         value,
  output logic                              err
);
  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] SensBias = 32'd32768;
  localparam logic [31:0] PressScale = 32'd50000;
  localparam logic [31:0] CorrSq = 32'd3038;
  localparam logic [31:0] CorrLin = 32'd0 - 32'd7357;
  localparam logic [31:0] CorrOfs = 32'd3791;

  logic [15:0] ac1, ac2, ac3, ac4;
  logic [31:0] ac56, b12, mcmd;
  logic [1:0]  oss;
  logic [31:0] temp_term;
  logic [18:0] raw;
  logic [31:0] t, acc, x1, b6, sq, b3, b4, b7, p, h, prod;
  logic [31:0] ma, mb, mp;
  logic        div_start, div_sgn, div_busy, div_zero;
  logic [31:0] div_num, div_den, quot;
  logic [31:0] ac1x, b3_pre, b3_rnd, acc_rnd, t_rnd;

  function automatic logic [31:0] sx(input logic [15:0] v);
    sx = {{16{v[15]}}, v};
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ac1 <= '0; ac2 <= '0; ac3 <= '0; ac4 <= '0;
      ac56 <= '0; b12 <= '0; mcmd <= '0; oss <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bpc_pkg::RegAc1:  ac1 <= cfg_data[15:0];
        bpc_pkg::RegAc2:  ac2 <= cfg_data[15:0];
        bpc_pkg::RegAc3:  ac3 <= cfg_data[15:0];
        bpc_pkg::RegAc4:  ac4 <= cfg_data[15:0];
        bpc_pkg::RegAc56: ac56 <= cfg_data;
        bpc_pkg::RegB12:  b12 <= cfg_data;
        bpc_pkg::RegMcMd: mcmd <= cfg_data;
        bpc_pkg::RegOss:  oss <= cfg_data[1:0];
      endcase
    end
  end

  // multiplier operand select, product registered
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      bpc_pkg::OP_T_MUL: begin ma = t; mb = {16'd0, ac56[31:16]}; end
      bpc_pkg::OP_P_SQ:  begin ma = b6; mb = b6; end
      bpc_pkg::OP_P_SQS: begin ma = sx(ac2); mb = b6; end
      bpc_pkg::OP_P_X2:  begin ma = sx(b12[15:0]); mb = sq; end
      bpc_pkg::OP_P_X3:  begin ma = sx(ac3); mb = b6; end
      bpc_pkg::OP_P_B3:  begin ma = sx(b12[31:16]); mb = sq; end
      bpc_pkg::OP_P_B4M: begin ma = {16'd0, ac4}; mb = t; end
      bpc_pkg::OP_P_B4:  begin ma = b7; mb = PressScale >> oss; end
      bpc_pkg::OP_P_H:   begin ma = CorrLin; mb = p; end
      bpc_pkg::OP_P_HH:  begin ma = h; mb = h; end
      bpc_pkg::OP_P_HM:  begin ma = prod; mb = CorrSq; end
      default: ;
    endcase
  end
  assign mp = ma * mb;

  // short sums feeding the sequenced updates
  assign ac1x = sx(ac1);
  assign b3_pre = {ac1x[29:0], 2'b00} + acc;
  assign b3_rnd = t + 32'd2;
  assign acc_rnd = acc + 32'd2;
  assign t_rnd = t + 32'd8;

  // divider operands
  assign div_start = (cmd.op == bpc_pkg::OP_T_DIV) || (cmd.op == bpc_pkg::OP_P_DIV);
  assign div_sgn = (cmd.op == bpc_pkg::OP_T_DIV);
  assign div_num = div_sgn ? {{5{mcmd[31]}}, mcmd[31:16], 11'd0}
                           : (b7[31] ? b7 : {b7[30:0], 1'b0});
  assign div_den = div_sgn ? t : b4;

  bpc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .sgn(div_sgn), .num(div_num),
    .den(div_den), .busy(div_busy), .zero(div_zero), .quot(quot)
  );
  assign sts.div_busy = div_busy;
  assign sts.div_zero = div_zero;

  // sequenced register updates
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_term <= '0;
      value <= '0;
      err <= 1'b0;
      raw <= '0;
      prod <= '0;
      t <= '0; acc <= '0; x1 <= '0; b6 <= '0; sq <= '0;
      b3 <= '0; b4 <= '0; b7 <= '0; p <= '0; h <= '0;
    end else begin
      if (cmd.load) raw <= raw_in;
      prod <= mp;
      unique case (cmd.op)
        bpc_pkg::OP_T_SUB: t <= {13'd0, raw} - {16'd0, ac56[15:0]};
        bpc_pkg::OP_T_X1:  x1 <= {{15{prod[31]}}, prod[31:15]};
        bpc_pkg::OP_T_DEN: t <= x1 + sx(mcmd[15:0]);
        bpc_pkg::OP_T_B5:  t <= x1 + quot;
        bpc_pkg::OP_T_FIN: begin
          err <= div_zero;
          if (div_zero) begin
            value <= '0;
          end else begin
            temp_term <= t;
            value <= {{4{t_rnd[31]}}, t_rnd[31:4]};
          end
        end
        bpc_pkg::OP_P_B6:  b6 <= temp_term - TempOffset;
        bpc_pkg::OP_P_SQS: sq <= {{12{prod[31]}}, prod[31:12]};
        bpc_pkg::OP_P_X2:  acc <= {{11{prod[31]}}, prod[31:11]};
        bpc_pkg::OP_P_X3:  acc <= acc + {{11{prod[31]}}, prod[31:11]};
        bpc_pkg::OP_P_B3: begin
          t <= b3_pre << oss;
          x1 <= {{13{prod[31]}}, prod[31:13]};
        end
        bpc_pkg::OP_P_B3F: begin
          b3 <= {{2{b3_rnd[31]}}, b3_rnd[31:2]};
          acc <= x1 + {{16{prod[31]}}, prod[31:16]};
        end
        bpc_pkg::OP_P_B4S: begin
          t <= {{2{acc_rnd[31]}}, acc_rnd[31:2]} + SensBias;
          b7 <= {13'd0, raw} - b3;
        end
        bpc_pkg::OP_P_B4:  b4 <= {15'd0, prod[31:15]};
        bpc_pkg::OP_P_B7:  b7 <= prod;
        bpc_pkg::OP_P_PQ:  p <= b7[31] ? {quot[30:0], 1'b0} : quot;
        bpc_pkg::OP_P_H:   h <= {{8{p[31]}}, p[31:8]};
        bpc_pkg::OP_P_HH:  x1 <= {{16{prod[31]}}, prod[31:16]};
        bpc_pkg::OP_P_X1:  acc <= {{16{prod[31]}}, prod[31:16]} + x1 + CorrOfs;
        bpc_pkg::OP_P_FIN: begin
          err <= div_zero;
          value <= div_zero ? 32'd0 : p + {{4{acc[31]}}, acc[31:4]};
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/bpc_ctrl.sv */
// controller sequencing the datapath steps for one item
`default_nettype none
module bpc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_action,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic                   out_kind,
  output bpc_pkg::dp_cmd_t       cmd,
  input  wire bpc_pkg::dp_sts_t  sts
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  bpc_pkg::op_t op;
  logic kind;

  assign in_stall = rst || (state != S_IDLE) || (out_valid && out_stall);
  assign cmd.load = in_valid && !in_stall;
  assign cmd.op = (state == S_RUN) ? op : bpc_pkg::OP_NONE;
  assign out_kind = kind;

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      op <= bpc_pkg::OP_NONE;
      kind <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd.load) begin
          kind <= in_action;
          op <= in_action ? bpc_pkg::OP_P_B6 : bpc_pkg::OP_T_SUB;
          state <= S_RUN;
        end
        S_RUN: begin
          if (op == bpc_pkg::OP_T_FIN || op == bpc_pkg::OP_P_FIN) begin
            state <= S_DONE;
          end else begin
            if (op == bpc_pkg::OP_T_DIV || op == bpc_pkg::OP_P_DIV) state <= S_WAIT;
            op <= bpc_pkg::op_t'(op + 5'd1);
          end
        end
        S_WAIT: if (!sts.div_busy) state <= S_RUN;
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/barometric_pressure_compensation.sv */
// top level of the barometric pressure compensation block
//  channel  direction  handshake         payload
//  in       input      in_valid/in_stall   action, raw_reading
//  out      output     out_valid/out_stall result_kind, result_value, divide_error
//  cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
// temperature and pressure results each run one controller step per cycle on the shared
// multiplier datapath and wait while the iterative divider works; a zero divisor skips the
// divide's iterations; the next item can be taken in the cycle the result is presented
// reset clears control, calibration registers and the stored temperature term
// a waiting result stalls input until it is taken; input stalls during reset
`default_nettype none
module barometric_pressure_compensation (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        action,
  input  wire logic [bpc_pkg::RawW-1:0]    raw_reading,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             result_kind,
  output logic [bpc_pkg::DataW-1:0]        result_value,
  output logic                             divide_error,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bpc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [bpc_pkg::DataW-1:0]   cfg_data
);
  bpc_pkg::dp_cmd_t cmd;
  bpc_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bpc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_action(action), .out_stall(out_stall), .out_valid(out_valid),
    .out_kind(result_kind), .cmd(cmd), .sts(sts)
  );

  bpc_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .raw_in(raw_reading), .cmd(cmd), .sts(sts),
    .value(result_value), .err(divide_error)
  );
endmodule
`default_nettype wire
